>>> design/tst_pkg.sv
// ----------------------------------------------------------------------------
// Trie stopword tokenizer package
// Sizes, codes, beat types and character helpers shared by the tokenizer
// and its checker.
// ----------------------------------------------------------------------------
package tst_pkg;

	localparam int ALPHABET_SIZE = 26;
	localparam int TRIE_NODES    = 4096;
	localparam int NODE_W        = $clog2(TRIE_NODES);
	localparam int CNT_W         = NODE_W + 1;
	localparam int SLOT_W        = $clog2(ALPHABET_SIZE);
	localparam int CHAR_W        = 8;
	localparam int POS_W         = 16;
	localparam int LEN_W         = 8;
	localparam int CFG_IDX_W     = 8;

	localparam logic [LEN_W-1:0] MAX_LEN_RESET = 8'd20;
	localparam logic [LEN_W-1:0] MIN_LEN_RESET = 8'd2;
	localparam logic [LEN_W-1:0] LEN_SAT       = '1;

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEN = 8'd1;

	localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7a;
	localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5a;
	localparam logic [CHAR_W-1:0] CH_DIGIT_0 = 8'h30;
	localparam logic [CHAR_W-1:0] CH_DIGIT_9 = 8'h39;

	typedef enum logic [1:0] {
		OP_STOP_CHAR = 2'd0,
		OP_STOP_END  = 2'd1,
		OP_TEXT_CHAR = 2'd2,
		OP_TEXT_END  = 2'd3
	} opcode_t;

	typedef struct packed {
		opcode_t           opcode;
		logic [CHAR_W-1:0] char_code;
		logic              stop_flag;
	} char_item_t;

	typedef struct packed {
		logic [POS_W-1:0] token_start;
		logic [LEN_W-1:0] token_length;
		logic             keep;
		logic             stem;
		logic             table_full;
	} token_item_t;

	function automatic logic is_digit(input logic [CHAR_W-1:0] c);
		return (c >= CH_DIGIT_0) && (c <= CH_DIGIT_9);
	endfunction

	function automatic logic is_word_char(input logic [CHAR_W-1:0] c);
		return ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ||
			((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) || is_digit(c);
	endfunction

	function automatic logic slot_ok(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] d;
		d = c - CH_LOWER_A;
		return (c >= CH_LOWER_A) && (c <= CH_LOWER_Z) && (int'(d) < ALPHABET_SIZE);
	endfunction

	function automatic logic [SLOT_W-1:0] slot_of(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] d;
		d = c - CH_LOWER_A;
		return d[SLOT_W-1:0];
	endfunction

endpackage

>>> design/trie_stopword_tokenizer.sv
// ----------------------------------------------------------------------------
// Trie stopword tokenizer
// Loads stopwords into a trie held in an edge row memory, then splits text
// into tokens and flags each one for keeping and stemming.
// ----------------------------------------------------------------------------
// Character beats enter on char_valid/char_data and are taken when char_stall
// is low. Opcodes load stopword letters, end a stopword, carry text letters
// or end the text. Token beats leave on tok_valid/tok_data and are taken
// when tok_stall is low. Length limits are written on the cfg channel, which
// is always ready.
// One character beat is taken per cycle while char_stall is low. The limit is the trie walk: the
// edge row read for one letter is registered and its selected lane forms
// the row address of the next letter in the following cycle.
// The closing beat is registered in s1, then its token in the output buffer.
// A two-entry output buffer lets the block keep taking beats while a token
// waits; char_stall also rises once both entries would hold a token.
// After reset the block clears the edge and end mark memories one node row
// per cycle, with char_stall held high; cfg writes are taken.
// ----------------------------------------------------------------------------
module trie_stopword_tokenizer import tst_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 char_valid,
	output logic                 char_stall,
	input  char_item_t           char_data,
	output logic                 tok_valid,
	input  logic                 tok_stall,
	output token_item_t          tok_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [LEN_W-1:0]     cfg_data
);

	logic [ALPHABET_SIZE-1:0][NODE_W-1:0] edge_mem [TRIE_NODES];
	logic                                 end_mem  [TRIE_NODES];

	logic [ALPHABET_SIZE-1:0][NODE_W-1:0] edge_row_s1;
	logic                                 end_mark_s1;
	logic                                 valid_s1;
	char_item_t                           item_s1;
	logic                                 edge_fwd_s1;
	logic [SLOT_W-1:0]                    edge_fwd_lane_s1;
	logic [NODE_W-1:0]                    edge_fwd_val_s1;
	logic                                 end_fwd_s1;
	logic                                 end_fwd_val_s1;

	logic               clr_busy_q;
	logic [NODE_W-1:0]  clr_row_q;

	logic [CNT_W-1:0]  nodes_used_q, nodes_used_nxt;
	logic [NODE_W-1:0] cursor_q, cursor_nxt;
	logic              load_failed_q, load_failed_nxt;
	logic [NODE_W-1:0] match_q, match_nxt;
	logic              nomatch_q, nomatch_nxt;
	logic              in_token_q, in_token_nxt;
	logic [POS_W-1:0]  start_pos_q, start_pos_nxt;
	logic [LEN_W-1:0]  run_len_q, run_len_nxt;
	logic              digit_first_q, digit_first_nxt;
	logic              seen_digit_q, seen_digit_nxt;
	logic              seen_letter_q, seen_letter_nxt;
	logic [POS_W-1:0]  position_q, position_nxt;
	logic              full_q, full_nxt;
	logic [LEN_W-1:0]  max_len_q, min_len_q;

	logic              accept;
	logic              slot_ok_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic [NODE_W-1:0] edge_val_s1;
	logic              mark_s1;
	logic              word_s1;
	logic              digit_s1;
	logic              nomatch_base;
	logic              alloc;
	logic              end_set;
	logic              close;
	logic              stop_hit;
	logic              keep;
	token_item_t       tok_item;

	logic [ALPHABET_SIZE-1:0] edge_wmask;
	logic [NODE_W-1:0]        edge_wrow;
	logic [NODE_W-1:0]        edge_wdata;
	logic                     end_we;
	logic [NODE_W-1:0]        end_waddr;
	logic                     end_wdata;
	logic [NODE_W-1:0]        rd_row;

	token_item_t buf_q [2];
	logic        wr_ptr_q, rd_ptr_q;
	logic [1:0]  count_q;
	logic        push, pop;
	logic [2:0]  occ;

	assign cfg_ready = 1'b1;
	assign accept    = char_valid && !char_stall;

	assign slot_ok_s1  = slot_ok(item_s1.char_code);
	assign slot_s1     = slot_of(item_s1.char_code);
	assign edge_val_s1 = (edge_fwd_s1 && (edge_fwd_lane_s1 == slot_s1)) ?
		edge_fwd_val_s1 : edge_row_s1[slot_s1];
	assign mark_s1     = end_fwd_s1 ? end_fwd_val_s1 : end_mark_s1;
	assign word_s1     = is_word_char(item_s1.char_code);
	assign digit_s1    = is_digit(item_s1.char_code);
	assign nomatch_base = in_token_q ? nomatch_q : 1'b0;

	always_comb begin
		nodes_used_nxt  = nodes_used_q;
		cursor_nxt      = cursor_q;
		load_failed_nxt = load_failed_q;
		match_nxt       = match_q;
		nomatch_nxt     = nomatch_q;
		in_token_nxt    = in_token_q;
		start_pos_nxt   = start_pos_q;
		run_len_nxt     = run_len_q;
		digit_first_nxt = digit_first_q;
		seen_digit_nxt  = seen_digit_q;
		seen_letter_nxt = seen_letter_q;
		position_nxt    = position_q;
		full_nxt        = full_q;
		alloc           = 1'b0;
		end_set         = 1'b0;
		close           = 1'b0;
		if (valid_s1) begin
			unique case (item_s1.opcode)
				OP_STOP_CHAR: begin
					if (!load_failed_q && slot_ok_s1) begin
						if (edge_val_s1 == '0) begin
							if (nodes_used_q >= CNT_W'(TRIE_NODES)) begin
								full_nxt        = 1'b1;
								load_failed_nxt = 1'b1;
							end else begin
								alloc          = 1'b1;
								cursor_nxt     = nodes_used_q[NODE_W-1:0];
								nodes_used_nxt = nodes_used_q + 1'b1;
							end
						end else begin
							cursor_nxt = edge_val_s1;
						end
					end
				end
				OP_STOP_END: begin
					end_set         = !load_failed_q;
					cursor_nxt      = '0;
					load_failed_nxt = 1'b0;
				end
				OP_TEXT_END: begin
					close        = in_token_q;
					position_nxt = '0;
				end
				OP_TEXT_CHAR: begin
					if (word_s1) begin
						if (!in_token_q) begin
							in_token_nxt    = 1'b1;
							start_pos_nxt   = position_q;
							run_len_nxt     = LEN_W'(1);
							digit_first_nxt = digit_s1;
							seen_digit_nxt  = digit_s1;
							seen_letter_nxt = !digit_s1;
							match_nxt       = '0;
							nomatch_nxt     = 1'b0;
						end else begin
							if (run_len_q != LEN_SAT) begin
								run_len_nxt = run_len_q + 1'b1;
							end
							seen_digit_nxt  = seen_digit_q || digit_s1;
							seen_letter_nxt = seen_letter_q || !digit_s1;
						end
						if (!nomatch_base && slot_ok_s1) begin
							if (edge_val_s1 == '0) begin
								nomatch_nxt = 1'b1;
							end else begin
								match_nxt = edge_val_s1;
							end
						end
					end else begin
						close = in_token_q;
					end
					position_nxt = position_q + 1'b1;
				end
			endcase
		end
		if (close) begin
			in_token_nxt = 1'b0;
			match_nxt    = '0;
			nomatch_nxt  = 1'b0;
		end
	end

	assign stop_hit = !nomatch_q && mark_s1;
	assign keep     = !((run_len_q > max_len_q) || (run_len_q < min_len_q) || stop_hit ||
		(digit_first_q && seen_letter_q));

	always_comb begin
		tok_item.token_start  = start_pos_q;
		tok_item.token_length = run_len_q;
		tok_item.keep         = keep;
		tok_item.stem         = keep && !seen_digit_q;
		tok_item.table_full   = full_q;
	end

	always_comb begin
		if (clr_busy_q) begin
			edge_wmask = '1;
			edge_wrow  = clr_row_q;
			edge_wdata = '0;
		end else begin
			edge_wmask = alloc ? (ALPHABET_SIZE'(1) << slot_s1) : '0;
			edge_wrow  = cursor_q;
			edge_wdata = nodes_used_q[NODE_W-1:0];
		end
		end_we    = clr_busy_q || alloc || end_set;
		end_waddr = clr_busy_q ? clr_row_q :
			(alloc ? nodes_used_q[NODE_W-1:0] : cursor_q);
		end_wdata = end_set && item_s1.stop_flag;
	end

	assign rd_row = (char_data.opcode == OP_STOP_CHAR) ? cursor_nxt :
		(in_token_nxt ? match_nxt : '0);

	always_ff @(posedge clk) begin
		for (int l = 0; l < ALPHABET_SIZE; l++) begin
			if (edge_wmask[l]) begin
				edge_mem[edge_wrow][l] <= edge_wdata;
			end
		end
		if (end_we) begin
			end_mem[end_waddr] <= end_wdata;
		end
		if (accept) begin
			edge_row_s1 <= edge_mem[rd_row];
			end_mark_s1 <= end_mem[match_nxt];
		end
	end

	always_ff @(posedge clk) begin
		item_s1          <= char_data;
		edge_fwd_lane_s1 <= slot_s1;
		edge_fwd_val_s1  <= edge_wdata;
		end_fwd_val_s1   <= end_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			edge_fwd_s1 <= 1'b0;
			end_fwd_s1  <= 1'b0;
			clr_busy_q  <= 1'b1;
			clr_row_q   <= '0;
		end else begin
			valid_s1    <= accept;
			edge_fwd_s1 <= accept && alloc && (cursor_q == rd_row);
			end_fwd_s1  <= accept && end_we && (end_waddr == match_nxt);
			if (clr_busy_q) begin
				clr_row_q <= clr_row_q + 1'b1;
				if (clr_row_q == NODE_W'(TRIE_NODES - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nodes_used_q  <= CNT_W'(1);
			cursor_q      <= '0;
			load_failed_q <= 1'b0;
			match_q       <= '0;
			nomatch_q     <= 1'b0;
			in_token_q    <= 1'b0;
			start_pos_q   <= '0;
			run_len_q     <= '0;
			digit_first_q <= 1'b0;
			seen_digit_q  <= 1'b0;
			seen_letter_q <= 1'b0;
			position_q    <= '0;
			full_q        <= 1'b0;
		end else begin
			nodes_used_q  <= nodes_used_nxt;
			cursor_q      <= cursor_nxt;
			load_failed_q <= load_failed_nxt;
			match_q       <= match_nxt;
			nomatch_q     <= nomatch_nxt;
			in_token_q    <= in_token_nxt;
			start_pos_q   <= start_pos_nxt;
			run_len_q     <= run_len_nxt;
			digit_first_q <= digit_first_nxt;
			seen_digit_q  <= seen_digit_nxt;
			seen_letter_q <= seen_letter_nxt;
			position_q    <= position_nxt;
			full_q        <= full_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
			min_len_q <= MIN_LEN_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_MAX_LEN: max_len_q <= cfg_data;
				CFG_MIN_LEN: min_len_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign push      = valid_s1 && close;
	assign tok_valid = (count_q != 2'd0);
	assign tok_data  = buf_q[rd_ptr_q];
	assign pop       = tok_valid && !tok_stall;
	assign occ       = 3'(count_q) + 3'(push) - 3'(pop);
	assign char_stall = clr_busy_q || (occ >= 3'd2);

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= tok_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= occ[1:0];
		end
	end

endmodule

>>> design/tst_checker.sv
// ----------------------------------------------------------------------------
// Trie stopword tokenizer checker
// Port level checks on the token channel, bound to the top level.
// ----------------------------------------------------------------------------
module tst_checker import tst_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        tok_valid,
	input logic        tok_stall,
	input token_item_t tok_data
);

	a_tok_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok_stall |=> tok_valid)
		else $error("token beat dropped while stalled");

	a_tok_stable: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok_stall |=> $stable(tok_data))
		else $error("token beat changed while stalled");

	a_stem_keep: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid |-> (!tok_data.stem || tok_data.keep))
		else $error("stem flag set on a dropped token");

	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid |-> (tok_data.token_length != '0))
		else $error("token beat with zero length");

endmodule

bind trie_stopword_tokenizer tst_checker u_tst_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.tok_valid (tok_valid),
	.tok_stall (tok_stall),
	.tok_data  (tok_data)
);
